/* rtl/bvsf_pkg.sv */
// bvsf_pkg: shared widths, register indexes and item structs for the safety filter
// no dependencies
`timescale 1ns / 1ps
package bvsf_pkg;
  localparam int unsigned VelW  = 16;
  localparam int unsigned DistW = 16;
  localparam int unsigned GradW = 16;
  localparam int unsigned CfgW  = 16;
  localparam int unsigned IdxW  = 1;
  localparam int unsigned SumW  = 33;   // sum of three squares
  localparam int unsigned RadW  = 27;   // sqrt(S * 2^20)
  localparam int unsigned QW    = 15;   // unit component magnitude
  localparam int unsigned NumW  = 40;   // |g| * 2^24 plus rounding
  localparam int unsigned PhiW  = 48;
  localparam int unsigned WW    = 64;
  localparam int unsigned FifoDepthDef = 4;
  localparam logic [CfgW-1:0] SafeDistRst  = 16'd128;
  localparam logic [CfgW-1:0] DecayRateRst = 16'd256;
  localparam logic [IdxW-1:0] RegSafeDist  = 1'b0;
  localparam logic [IdxW-1:0] RegDecayRate = 1'b1;

  typedef struct packed {
    logic signed [VelW-1:0]  vx;
    logic signed [VelW-1:0]  vy;
    logic signed [VelW-1:0]  vz;
    logic                    command_present;
    logic                    map_valid;
    logic signed [DistW-1:0] obstacle_distance;
    logic signed [GradW-1:0] grad_x;
    logic signed [GradW-1:0] grad_y;
    logic signed [GradW-1:0] grad_z;
  } in_item_t;

  typedef struct packed {
    logic signed [VelW-1:0] vx;
    logic signed [VelW-1:0] vy;
    logic signed [VelW-1:0] vz;
    logic                   was_corrected;
  } out_item_t;

  // front to back: classified item
  typedef struct packed {
    logic signed [VelW-1:0]  vx;
    logic signed [VelW-1:0]  vy;
    logic signed [VelW-1:0]  vz;
    logic signed [DistW-1:0] obs_dist;
    logic signed [GradW-1:0] gx;
    logic signed [GradW-1:0] gy;
    logic signed [GradW-1:0] gz;
  } work_t;
endpackage

/* rtl/bvsf_if.sv */
// bvsf_in_if / bvsf_out_if / bvsf_cfg_if: valid-ready channels
// depends on bvsf_pkg
`timescale 1ns / 1ps
interface bvsf_in_if;
  logic valid;
  logic ready;
  bvsf_pkg::in_item_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface bvsf_out_if;
  logic valid;
  logic ready;
  bvsf_pkg::out_item_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface bvsf_cfg_if;
  logic valid;
  logic ready;
  logic [bvsf_pkg::IdxW-1:0] index;
  logic [bvsf_pkg::CfgW-1:0] data;
  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

/* rtl/bvsf_fifo.sv */
// bvsf_fifo: short queue between front and back
// depends on bvsf_pkg
`timescale 1ns / 1ps
module bvsf_fifo #(
  parameter int unsigned Depth = bvsf_pkg::FifoDepthDef
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  bvsf_pkg::work_t  push_data_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic             empty_o,
  output bvsf_pkg::work_t  pop_data_o
);
  localparam int unsigned AW = (Depth > 1) ? $clog2(Depth) : 1;
  bvsf_pkg::work_t mem [Depth];
  logic [AW-1:0] wp_q, rp_q;
  logic [AW:0]   cnt_q;

  function automatic logic [AW-1:0] inc(input logic [AW-1:0] p);
    inc = (p == AW'(Depth - 1)) ? '0 : p + 1'b1;
  endfunction

  assign full_o     = (cnt_q == (AW + 1)'(Depth));
  assign empty_o    = (cnt_q == '0);
  assign pop_data_o = mem[rp_q];

  always_ff @(posedge clk_i) begin
    if (push_i && !full_o) mem[wp_q] <= push_data_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q <= '0; rp_q <= '0; cnt_q <= '0;
    end else begin
      if (push_i && !full_o) wp_q <= inc(wp_q);
      if (pop_i && !empty_o) rp_q <= inc(rp_q);
      cnt_q <= cnt_q + (AW + 1)'(push_i && !full_o) - (AW + 1)'(pop_i && !empty_o);
    end
  end

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    full_o && !pop_i |=> full_o) else $error("fifo count lost");
  a_cnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= (AW + 1)'(Depth)) else $error("fifo count out of range");
  a_empty_pop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    empty_o && !push_i |=> empty_o) else $error("fifo emptied wrongly");
endmodule

/* rtl/bvsf_front.sv */
// bvsf_front: accepts items, drops those without command, map or gradient
// depends on bvsf_pkg
`timescale 1ns / 1ps
module bvsf_front (
  input  logic             clk_i,
  input  logic             rst_ni,
  bvsf_in_if.sink          in_ch,
  input  logic             full_i,
  output logic             push_o,
  output bvsf_pkg::work_t  push_data_o
);
  logic keep_d, keep_q;
  bvsf_pkg::work_t w_q;
  logic acc;

  assign in_ch.ready = !(keep_q && full_i);
  assign acc = in_ch.valid && in_ch.ready;
  assign keep_d = in_ch.data.command_present && in_ch.data.map_valid &&
                  ((in_ch.data.grad_x != '0) || (in_ch.data.grad_y != '0) ||
                   (in_ch.data.grad_z != '0));
  assign push_o = keep_q;
  assign push_data_o = w_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      keep_q <= 1'b0;
    end else if (in_ch.ready) begin
      keep_q <= acc && keep_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ch.ready) begin
      w_q <= '{vx: in_ch.data.vx, vy: in_ch.data.vy, vz: in_ch.data.vz,
               obs_dist: in_ch.data.obstacle_distance, gx: in_ch.data.grad_x,
               gy: in_ch.data.grad_y, gz: in_ch.data.grad_z};
    end
  end
endmodule

/* rtl/bvsf_back.sv */
// bvsf_back: pipelined norm, sqrt, divide, dot product and correction
// depends on bvsf_pkg
`timescale 1ns / 1ps
module bvsf_back (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic [bvsf_pkg::CfgW-1:0] safe_dist_i,
  input  logic [bvsf_pkg::CfgW-1:0] decay_rate_i,
  input  logic                     empty_i,
  input  bvsf_pkg::work_t          pop_data_i,
  output logic                     pop_o,
  bvsf_out_if.source               out_ch
);
  localparam int unsigned SqS = bvsf_pkg::RadW;        // one result bit per stage
  localparam int unsigned DvS = bvsf_pkg::QW;          // one quotient bit per stage
  localparam int unsigned NS  = 1 + SqS + DvS + 5;     // total stages
  localparam int unsigned XW  = 2 * bvsf_pkg::RadW + 2;
  localparam int unsigned RW  = bvsf_pkg::RadW;
  localparam int unsigned NW  = bvsf_pkg::NumW;

  logic adv;
  logic [NS-1:0] vld_q;
  logic out_full;

  // output holding, no skid buffer: pipe advances when output slot free or being taken
  assign out_full = out_ch.valid && !out_ch.ready;
  assign adv = !out_full;
  assign pop_o = adv && !empty_i;

  // stage 0: squares and distance margin
  bvsf_pkg::work_t s0_w_q;
  logic [bvsf_pkg::SumW-1:0] s0_s_q;
  logic signed [bvsf_pkg::DistW+1:0] s0_h_q;
  logic signed [2*bvsf_pkg::GradW-1:0] gxx, gyy, gzz;
  assign gxx = pop_data_i.gx * pop_data_i.gx;
  assign gyy = pop_data_i.gy * pop_data_i.gy;
  assign gzz = pop_data_i.gz * pop_data_i.gz;
  always_ff @(posedge clk_i) begin
    if (adv) begin
      s0_w_q <= pop_data_i;
      s0_s_q <= bvsf_pkg::SumW'($unsigned(gxx)) + bvsf_pkg::SumW'($unsigned(gyy)) +
                bvsf_pkg::SumW'($unsigned(gzz));
      s0_h_q <= (bvsf_pkg::DistW + 2)'(pop_data_i.obs_dist) -
                $signed({2'b00, safe_dist_i});
    end
  end

  // sqrt stages: restoring, one result bit each
  bvsf_pkg::work_t sq_w_q [SqS];
  logic signed [bvsf_pkg::DistW+1:0] sq_h_q [SqS];
  logic [XW-1:0] sq_rem_q [SqS];
  logic [RW-1:0] sq_res_q [SqS];
  logic [XW-1:0] sq_x_q [SqS];
  for (genvar k = 0; k < SqS; k++) begin : g_sq
    logic [XW-1:0] x_in, rem_in, trial, rem_sh;
    logic [RW-1:0] res_in;
    bvsf_pkg::work_t w_in;
    logic signed [bvsf_pkg::DistW+1:0] h_in;
    if (k == 0) begin : g_first
      assign x_in   = XW'({s0_s_q, 20'd0});
      assign rem_in = '0;
      assign res_in = '0;
      assign w_in   = s0_w_q;
      assign h_in   = s0_h_q;
    end else begin : g_next
      assign x_in   = sq_x_q[k-1];
      assign rem_in = sq_rem_q[k-1];
      assign res_in = sq_res_q[k-1];
      assign w_in   = sq_w_q[k-1];
      assign h_in   = sq_h_q[k-1];
    end
    assign rem_sh = {rem_in[XW-3:0], x_in[2*(SqS-1-k)+1 -: 2]};
    assign trial  = XW'({res_in, 2'b01});
    always_ff @(posedge clk_i) begin
      if (adv) begin
        sq_x_q[k] <= x_in;
        sq_w_q[k] <= w_in;
        sq_h_q[k] <= h_in;
        if (rem_sh >= trial) begin
          sq_rem_q[k] <= rem_sh - trial;
          sq_res_q[k] <= {res_in[RW-2:0], 1'b1};
        end else begin
          sq_rem_q[k] <= rem_sh;
          sq_res_q[k] <= {res_in[RW-2:0], 1'b0};
        end
      end
    end
  end

  // divide stages: three lanes, one quotient bit each, values capped at 2^14 in stage A
  bvsf_pkg::work_t dv_w_q [DvS];
  logic signed [bvsf_pkg::DistW+1:0] dv_h_q [DvS];
  logic [RW-1:0] dv_r_q [DvS];
  logic [NW-1:0] dv_rem_q [DvS][3];
  logic [bvsf_pkg::QW-1:0] dv_q_q [DvS][3];
  logic [NW-1:0] dv_num_q [DvS][3];
  logic [2:0] dv_big_q [DvS];
  for (genvar k = 0; k < DvS; k++) begin : g_dv
    bvsf_pkg::work_t w_in;
    logic signed [bvsf_pkg::DistW+1:0] h_in;
    logic [RW-1:0] r_in;
    logic [NW-1:0] num_in [3];
    logic [NW-1:0] rem_in [3];
    logic [bvsf_pkg::QW-1:0] q_in [3];
    logic [2:0] big_in;
    if (k == 0) begin : g_first
      logic signed [bvsf_pkg::GradW-1:0] g [3];
      assign w_in = sq_w_q[SqS-1];
      assign h_in = sq_h_q[SqS-1];
      assign r_in = sq_res_q[SqS-1];
      assign g[0] = w_in.gx;
      assign g[1] = w_in.gy;
      assign g[2] = w_in.gz;
      for (genvar j = 0; j < 3; j++) begin : g_l
        logic [bvsf_pkg::GradW-1:0] mag;
        logic [NW-1:0] num;
        assign mag = g[j][bvsf_pkg::GradW-1] ? bvsf_pkg::GradW'(-g[j])
                                              : bvsf_pkg::GradW'(g[j]);
        assign num = NW'({mag, 24'd0}) + NW'(r_in >> 1);
        // quotient >= 2^15 means capped anyway; start from numerator shifted
        assign big_in[j] = (num >> bvsf_pkg::QW) >= NW'(r_in);
        assign num_in[j] = num;
        assign rem_in[j] = NW'(num >> bvsf_pkg::QW);
        assign q_in[j] = '0;
      end
    end else begin : g_next
      assign w_in = dv_w_q[k-1];
      assign h_in = dv_h_q[k-1];
      assign r_in = dv_r_q[k-1];
      assign big_in = dv_big_q[k-1];
      for (genvar j = 0; j < 3; j++) begin : g_l
        assign num_in[j] = dv_num_q[k-1][j];
        assign rem_in[j] = dv_rem_q[k-1][j];
        assign q_in[j] = dv_q_q[k-1][j];
      end
    end
    always_ff @(posedge clk_i) begin
      if (adv) begin
        dv_w_q[k] <= w_in;
        dv_h_q[k] <= h_in;
        dv_r_q[k] <= r_in;
        dv_big_q[k] <= big_in;
        for (int j = 0; j < 3; j++) begin
          logic [NW-1:0] rs;
          rs = {rem_in[j][NW-2:0], num_in[j][DvS-1-k]};
          dv_num_q[k][j] <= num_in[j];
          if (rs >= NW'(r_in)) begin
            dv_rem_q[k][j] <= rs - NW'(r_in);
            dv_q_q[k][j] <= {q_in[j][bvsf_pkg::QW-2:0], 1'b1};
          end else begin
            dv_rem_q[k][j] <= rs;
            dv_q_q[k][j] <= {q_in[j][bvsf_pkg::QW-2:0], 1'b0};
          end
        end
      end
    end
  end

  // stage A: signed unit components
  bvsf_pkg::work_t a_w_q;
  logic signed [bvsf_pkg::DistW+1:0] a_h_q;
  logic signed [bvsf_pkg::QW:0] a_n_q [3];
  always_ff @(posedge clk_i) begin
    if (adv) begin
      a_w_q <= dv_w_q[DvS-1];
      a_h_q <= dv_h_q[DvS-1];
      for (int j = 0; j < 3; j++) begin
        logic [bvsf_pkg::QW-1:0] q;
        logic neg;
        q = dv_q_q[DvS-1][j];
        if (dv_big_q[DvS-1][j] || q > bvsf_pkg::QW'(16384)) q = bvsf_pkg::QW'(16384);
        neg = (j == 0) ? dv_w_q[DvS-1].gx[bvsf_pkg::GradW-1] :
              (j == 1) ? dv_w_q[DvS-1].gy[bvsf_pkg::GradW-1] :
                         dv_w_q[DvS-1].gz[bvsf_pkg::GradW-1];
        a_n_q[j] <= neg ? -$signed({1'b0, q}) : $signed({1'b0, q});
      end
    end
  end

  // stage B: products
  bvsf_pkg::work_t b_w_q;
  logic signed [bvsf_pkg::QW:0] b_n_q [3];
  logic signed [31:0] b_p_q [3];
  logic signed [34:0] b_lh_q;
  always_ff @(posedge clk_i) begin
    if (adv) begin
      b_w_q <= a_w_q;
      b_n_q <= a_n_q;
      b_p_q[0] <= a_n_q[0] * a_w_q.vx;
      b_p_q[1] <= a_n_q[1] * a_w_q.vy;
      b_p_q[2] <= a_n_q[2] * a_w_q.vz;
      b_lh_q <= $signed({1'b0, decay_rate_i}) * a_h_q;
    end
  end

  // stage C: phi
  bvsf_pkg::work_t c_w_q;
  logic signed [bvsf_pkg::QW:0] c_n_q [3];
  logic signed [bvsf_pkg::PhiW-1:0] c_phi_q;
  always_ff @(posedge clk_i) begin
    if (adv) begin
      c_w_q <= b_w_q;
      c_n_q <= b_n_q;
      c_phi_q <= bvsf_pkg::PhiW'(b_p_q[0]) + bvsf_pkg::PhiW'(b_p_q[1]) +
                 bvsf_pkg::PhiW'(b_p_q[2]) + (bvsf_pkg::PhiW'(b_lh_q) <<< 10);
    end
  end

  // stage D: corrected velocities at full precision
  bvsf_pkg::work_t d_w_q;
  logic d_neg_q;
  logic signed [bvsf_pkg::WW-1:0] d_wx_q, d_wy_q, d_wz_q;
  always_ff @(posedge clk_i) begin
    if (adv) begin
      d_w_q <= c_w_q;
      d_neg_q <= c_phi_q < 0;
      d_wx_q <= (bvsf_pkg::WW'(c_w_q.vx) <<< 28) -
                bvsf_pkg::WW'(c_n_q[0]) * bvsf_pkg::WW'(c_phi_q);
      d_wy_q <= (bvsf_pkg::WW'(c_w_q.vy) <<< 28) -
                bvsf_pkg::WW'(c_n_q[1]) * bvsf_pkg::WW'(c_phi_q);
      d_wz_q <= (bvsf_pkg::WW'(c_w_q.vz) <<< 28) -
                bvsf_pkg::WW'(c_n_q[2]) * bvsf_pkg::WW'(c_phi_q);
    end
  end

  // stage E: round and saturate when corrected, else pass the input velocity
  bvsf_pkg::out_item_t e_q;
  function automatic logic [bvsf_pkg::VelW-1:0] rsat(input logic signed [bvsf_pkg::WW-1:0] w);
    logic [bvsf_pkg::WW-1:0] mag, q;
    mag = w[bvsf_pkg::WW-1] ? bvsf_pkg::WW'(-w) : bvsf_pkg::WW'(w);
    q = (mag + (64'd1 << 27)) >> 28;
    if (w[bvsf_pkg::WW-1]) rsat = (q > 64'd32768) ? 16'h8000 : 16'(-q);
    else rsat = (q > 64'd32767) ? 16'h7fff : 16'(q);
  endfunction
  always_ff @(posedge clk_i) begin
    if (adv) begin
      if (d_neg_q) begin
        e_q <= '{vx: rsat(d_wx_q), vy: rsat(d_wy_q), vz: rsat(d_wz_q),
                 was_corrected: 1'b1};
      end else begin
        e_q <= '{vx: d_w_q.vx, vy: d_w_q.vy, vz: d_w_q.vz, was_corrected: 1'b0};
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) vld_q <= '0;
    else if (adv) vld_q <= {vld_q[NS-2:0], !empty_i};
  end

  assign out_ch.valid = vld_q[NS-1];
  assign out_ch.data  = e_q;

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_full |=> out_ch.valid && $stable(e_q)) else $error("result dropped");
  a_no_pop_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_full |-> !pop_o) else $error("pop while stalled");
  a_pipe_frozen: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_full |=> $stable(vld_q)) else $error("pipe moved while stalled");
endmodule

/* rtl/barrier_velocity_safety_filter.sv */
// Barrier velocity safety filter. Takes one item per cycle while not stalled and passes it
// through a fully pipelined back end of 48 stages (squares, 27 sqrt bit stages, 15 divide
// bit stages, unit vector, products, phi, correction and rounding). A result passes the
// front register, the queue and then that pipeline; throughput is one item per cycle,
// a stalled output freezes the back end and the input stalls once the queue fills.
// Items without command, map or gradient give no result.
// depends on bvsf_pkg, bvsf_if, bvsf_front, bvsf_fifo, bvsf_back
`timescale 1ns / 1ps
module barrier_velocity_safety_filter #(
  parameter int unsigned FifoDepth = bvsf_pkg::FifoDepthDef
) (
  input  logic    clk_i,
  input  logic    rst_ni,
  bvsf_cfg_if.sink cfg,
  bvsf_in_if.sink  in_ch,
  bvsf_out_if.source out_ch
);
  logic [bvsf_pkg::CfgW-1:0] safe_dist_q, decay_rate_q;
  logic push, full, pop, empty;
  bvsf_pkg::work_t push_data, pop_data;

  assign cfg.ready = 1'b1;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      safe_dist_q  <= bvsf_pkg::SafeDistRst;
      decay_rate_q <= bvsf_pkg::DecayRateRst;
    end else if (cfg.valid) begin
      case (cfg.index)
        bvsf_pkg::RegSafeDist:  safe_dist_q  <= cfg.data;
        bvsf_pkg::RegDecayRate: decay_rate_q <= cfg.data;
        default: ;
      endcase
    end
  end

  bvsf_front u_front (.clk_i, .rst_ni, .in_ch, .full_i(full), .push_o(push),
                      .push_data_o(push_data));
  bvsf_fifo #(.Depth(FifoDepth)) u_fifo (.clk_i, .rst_ni, .push_i(push),
    .push_data_i(push_data), .full_o(full), .pop_i(pop), .empty_o(empty),
    .pop_data_o(pop_data));
  bvsf_back u_back (.clk_i, .rst_ni, .safe_dist_i(safe_dist_q),
    .decay_rate_i(decay_rate_q), .empty_i(empty), .pop_data_i(pop_data),
    .pop_o(pop), .out_ch);
endmodule

/* test/barrier_velocity_safety_filter_tb.sv */
// testbench for barrier_velocity_safety_filter: random and directed velocity items,
// each result checked against a bit-exact integer model of the barrier correction
// depends on bvsf_pkg, bvsf_if and the filter rtl
`timescale 1ns / 1ps
module barrier_velocity_safety_filter_tb;
  import bvsf_pkg::*;

  localparam int unsigned Latency    = 80;
  localparam longint      CycleLimit = 200000;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  bvsf_cfg_if cfg ();
  bvsf_in_if  in_ch ();
  bvsf_out_if out_ch ();

  barrier_velocity_safety_filter i_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg    (cfg),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  always #5 clk_i = ~clk_i;

  in_item_t   pending_q[$];
  out_item_t  filtered_q[$];
  logic [CfgW-1:0] safe_dist_m, decay_m;
  int unsigned mismatches = 0;
  longint cycles = 0;
  bit quiet_in = 1'b0, quiet_out = 1'b0;
  int unsigned hold_cycles = 0;
  bit cfg_busy = 1'b0;
  bit in_taken = 1'b0, cfg_taken = 1'b0;
  logic [IdxW-1:0] cfg_idx;
  logic [CfgW-1:0] cfg_val;

  function automatic longint unsigned sqrt_floor(longint unsigned x);
    longint unsigned res, bitv;
    res = 0;
    bitv = 64'd1 << 62;
    while (bitv > x) bitv >>= 2;
    while (bitv != 0) begin
      if (x >= res + bitv) begin
        x -= res + bitv;
        res = (res >> 1) + bitv;
      end else begin
        res >>= 1;
      end
      bitv >>= 2;
    end
    return res;
  endfunction

  function automatic longint unit_part(longint g, longint unsigned r);
    longint unsigned mag, q;
    mag = (g < 0) ? -g : g;
    q = ((mag << 24) + (r >> 1)) / r;
    if (q > 16384) q = 16384;
    return (g < 0) ? -longint'(q) : longint'(q);
  endfunction

  function automatic logic [VelW-1:0] round_to_vel(longint w);
    longint unsigned mag, q;
    mag = (w < 0) ? -w : w;
    q = (mag + (64'd1 << 27)) >> 28;
    if (w < 0) return (q > 32768) ? 16'h8000 : 16'(-longint'(q));
    return (q > 32767) ? 16'h7fff : 16'(q);
  endfunction

  // returns 1 and fills res when the item yields a filtered velocity
  function automatic bit filter_velocity(input in_item_t it, output out_item_t res);
    longint v[3], g[3], n[3];
    longint unsigned r;
    longint dot, phi, h;
    v[0] = it.vx; v[1] = it.vy; v[2] = it.vz;
    g[0] = it.grad_x; g[1] = it.grad_y; g[2] = it.grad_z;
    res = '0;
    if (!it.command_present || !it.map_valid) return 0;
    if (g[0] == 0 && g[1] == 0 && g[2] == 0) return 0;
    r = sqrt_floor(longint'(g[0]*g[0] + g[1]*g[1] + g[2]*g[2]) << 20);
    if (r == 0) return 0;
    dot = 0;
    for (int i = 0; i < 3; i++) begin
      n[i] = unit_part(g[i], r);
      dot += n[i] * v[i];
    end
    h = longint'(it.obstacle_distance) - longint'({1'b0, safe_dist_m});
    phi = dot + longint'({1'b0, decay_m}) * h * 1024;
    if (phi < 0) begin
      res.vx = round_to_vel(v[0] * (64'sd1 <<< 28) - n[0] * phi);
      res.vy = round_to_vel(v[1] * (64'sd1 <<< 28) - n[1] * phi);
      res.vz = round_to_vel(v[2] * (64'sd1 <<< 28) - n[2] * phi);
      res.was_corrected = 1'b1;
    end else begin
      res.vx = it.vx; res.vy = it.vy; res.vz = it.vz;
      res.was_corrected = 1'b0;
    end
    return 1;
  endfunction

  task automatic report(input string what, input logic [15:0] got, input logic [15:0] exp);
    $display("mismatch %s: got %h expected %h at cycle %0d", what, got, exp, cycles);
    mismatches++;
  endtask

  function automatic in_item_t rand_item(bit mostly_valid);
    in_item_t it;
    logic [159:0] raw;
    raw = {$urandom, $urandom, $urandom, $urandom, $urandom};
    it = raw[$bits(in_item_t)-1:0];
    if (mostly_valid) begin
      it.command_present = ($urandom_range(0, 9) != 0);
      it.map_valid = ($urandom_range(0, 9) != 0);
      case ($urandom_range(0, 5))
        0: it.grad_x = GradW'($urandom_range(0, 3) - 1);
        1: begin it.grad_y = '0; it.grad_z = '0; end
        2: it.obstacle_distance = DistW'($urandom_range(0, 1024) - 512);
        3: begin it.grad_x = '0; it.grad_y = '0; it.grad_z = '0; end
        default: ;
      endcase
    end
    return it;
  endfunction

  task automatic add_item(input logic [15:0] vx, vy, vz, input bit cmd, mv,
                          input logic [15:0] d, gx, gy, gz);
    in_item_t it;
    it = {vx, vy, vz, cmd, mv, d, gx, gy, gz};
    pending_q.push_back(it);
  endtask

  // driver: new item or hold, and config writes, at the falling edge
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (!in_ch.valid || in_taken) begin
        if (pending_q.size() != 0 && (quiet_in || $urandom_range(0, 99) >= 33)) begin
          in_ch.data  <= pending_q.pop_front();
          in_ch.valid <= 1'b1;
        end else begin
          in_ch.valid <= 1'b0;
        end
      end
      if (cfg_taken) cfg.valid <= 1'b0;
      else if (cfg_busy && !cfg.valid) begin
        cfg.valid <= 1'b1;
        cfg.index <= cfg_idx;
        cfg.data  <= cfg_val;
      end
    end
  end

  // receiver: random idling and long holds
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (hold_cycles != 0) begin
        out_ch.ready <= 1'b0;
        hold_cycles <= hold_cycles - 1;
      end else begin
        out_ch.ready <= quiet_out || ($urandom_range(0, 99) >= 33);
      end
    end
  end

  // monitor: accepted items and results at the rising edge
  always @(posedge clk_i) begin
    out_item_t exp_res, got;
    cycles <= cycles + 1;
    in_taken <= in_ch.valid && in_ch.ready;
    cfg_taken <= cfg.valid && cfg.ready;
    if (rst_ni) begin
      if (in_ch.valid && in_ch.ready && filter_velocity(in_ch.data, exp_res))
        filtered_q.push_back(exp_res);
      if (cfg.valid && cfg.ready) begin
        if (cfg.index == RegSafeDist) safe_dist_m = cfg.data;
        else decay_m = cfg.data;
        cfg_busy <= 1'b0;
      end
      if (out_ch.valid && out_ch.ready) begin
        got = out_ch.data;
        if (filtered_q.size() == 0) begin
          report("unexpected result", got.vx, 16'h0000);
        end else begin
          exp_res = filtered_q.pop_front();
          if (got.vx !== exp_res.vx) report("safe_vx", got.vx, exp_res.vx);
          if (got.vy !== exp_res.vy) report("safe_vy", got.vy, exp_res.vy);
          if (got.vz !== exp_res.vz) report("safe_vz", got.vz, exp_res.vz);
          if (got.was_corrected !== exp_res.was_corrected)
            report("was_corrected", 16'(got.was_corrected), 16'(exp_res.was_corrected));
        end
      end
    end
    if (cycles > CycleLimit) begin
      $display("timeout");
      $display("end of test: mismatches");
      $finish;
    end
  end

  task automatic write_reg(input logic [IdxW-1:0] idx, input logic [CfgW-1:0] val);
    cfg_idx = idx;
    cfg_val = val;
    cfg_busy = 1'b1;
    while (cfg_busy) @(posedge clk_i);
  endtask

  task automatic drain();
    while (pending_q.size() != 0 || in_ch.valid || filtered_q.size() != 0)
      @(posedge clk_i);
    repeat (Latency) @(posedge clk_i);
  endtask

  task automatic random_phase(input int unsigned count);
    for (int i = 0; i < count; i++) pending_q.push_back(rand_item($urandom_range(0, 9) != 0));
  endtask

  initial begin
    in_ch.valid = 1'b0;
    in_ch.data = '0;
    out_ch.ready = 1'b0;
    cfg.valid = 1'b0;
    cfg.index = RegSafeDist;
    cfg.data = '0;
    safe_dist_m = SafeDistRst;
    decay_m = DecayRateRst;
    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // directed: extremes, flags off, zero gradient, tiny corrections
    add_item(16'h1000, 16'h0000, 16'h0000, 1'b1, 1'b1, 16'h0000, 16'hc000, 16'h0000,
             16'h0000);
    add_item(16'h7fff, 16'h7fff, 16'h7fff, 1'b1, 1'b1, 16'h8000, 16'h8000, 16'h8000,
             16'h8000);
    add_item(16'h8000, 16'h8000, 16'h8000, 1'b1, 1'b1, 16'h8000, 16'h7fff, 16'h7fff,
             16'h7fff);
    add_item(16'h7fff, 16'h8000, 16'h0001, 1'b1, 1'b1, 16'h7fff, 16'h0001, 16'h0000,
             16'h0000);
    add_item(16'h1000, 16'h0000, 16'h0000, 1'b0, 1'b1, 16'h0000, 16'h4000, 16'h0000,
             16'h0000);
    add_item(16'h1000, 16'h0000, 16'h0000, 1'b1, 1'b0, 16'h0000, 16'h4000, 16'h0000,
             16'h0000);
    add_item(16'h1000, 16'h0000, 16'h0000, 1'b1, 1'b1, 16'h0000, 16'h0000, 16'h0000,
             16'h0000);
    add_item(16'h0000, 16'h0000, 16'h0000, 1'b1, 1'b1, 16'h007f, 16'h0001, 16'h0000,
             16'h0000);
    add_item(16'hffff, 16'h0000, 16'h0000, 1'b1, 1'b1, 16'h0080, 16'h0000, 16'hffff,
             16'h0000);
    add_item(16'h0100, 16'h0200, 16'hfe00, 1'b1, 1'b1, 16'h0080, 16'h2000, 16'h2000,
             16'h2000);
    add_item(16'h8000, 16'h7fff, 16'h0000, 1'b1, 1'b1, 16'h0200, 16'h0000, 16'h0000,
             16'h8000);
    drain();

    write_reg(RegSafeDist, 16'hffff);
    write_reg(RegDecayRate, 16'hffff);
    random_phase(200);
    drain();

    write_reg(RegSafeDist, 16'h0000);
    write_reg(RegDecayRate, 16'h0000);
    quiet_in = 1'b1;
    quiet_out = 1'b1;
    random_phase(200);
    drain();

    // receiver stalls long while the sender keeps offering
    quiet_out = 1'b0;
    write_reg(RegSafeDist, 16'h0100);
    write_reg(RegDecayRate, 16'h0040);
    hold_cycles = 300;
    random_phase(400);
    drain();
    quiet_in = 1'b0;

    write_reg(RegSafeDist, 16'd128);
    write_reg(RegDecayRate, 16'd256);
    random_phase(540);
    drain();

    if (mismatches == 0) $display("end of test: clean");
    else $display("end of test: mismatches");
    $finish;
  end
endmodule

/* files.f */
rtl/bvsf_pkg.sv
rtl/bvsf_if.sv
rtl/bvsf_fifo.sv
rtl/bvsf_front.sv
rtl/bvsf_back.sv
rtl/barrier_velocity_safety_filter.sv
test/barrier_velocity_safety_filter_tb.sv
